FILE: rtl/sce_pkg.sv
package sce_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int GAIN_BITS       = 16;
  localparam int DATA_BITS       = 32;
  localparam int ADDR_BITS       = 4;
  localparam int WORK_BITS       = 40;
  localparam int CORDIC_BITS     = WORK_BITS + 3;
  localparam int ANGLE_BITS      = 32;
  localparam int ANGLE_STEPS_MAX = 24;
  localparam int WEIGHT_BITS     = 17;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;
  typedef logic [ANGLE_BITS-1:0]         angle_t;
  typedef logic [WEIGHT_BITS-1:0]        weight_t;

  typedef struct packed {
    sample_t left_re;
    sample_t left_im;
    sample_t right_re;
    sample_t right_im;
    logic    last_bin;
  } item_t;

  typedef struct packed {
    sample_t out_left_re;
    sample_t out_left_im;
    sample_t out_right_re;
    sample_t out_right_im;
    logic    frame_end;
  } result_t;

  // word handed from the front to the back through the queue
  typedef struct packed {
    item_t  item;
    logic   pick_right;
    angle_t phase_left;
    angle_t phase_right;
  } word_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } queue_status_t;

  typedef enum logic [1:0] {
    REG_GAIN_LEFT   = 2'd0,
    REG_GAIN_CENTER = 2'd1,
    REG_GAIN_RIGHT  = 2'd2
  } reg_index_t;

  localparam gain_t   GAIN_UNITY  = 16'sd16384;
  localparam weight_t WEIGHT_ONE  = 17'd65536;
  localparam angle_t  HALF_TURN   = 32'h8000_0000;

  localparam logic [ANGLE_BITS-1:0] ANGLE_TAB [ANGLE_STEPS_MAX] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // unsigned Q1.16 product, rounded
  function automatic weight_t mul16(input weight_t a, input weight_t b);
    logic [2*WEIGHT_BITS-1:0] p;
    p = (2*WEIGHT_BITS)'(a) * (2*WEIGHT_BITS)'(b) + (2*WEIGHT_BITS)'(32768);
    return WEIGHT_BITS'(p >> 16);
  endfunction

endpackage

FILE: rtl/sce_cordic.sv
module sce_cordic #(
  parameter int STEPS = 16
) (
  input  logic             clk,
  input  sce_pkg::sample_t re,
  input  sce_pkg::sample_t im,
  output sce_pkg::angle_t  phase
);
  import sce_pkg::*;

  localparam int SHIFT = WORK_BITS - SAMPLE_BITS;

  logic signed [CORDIC_BITS-1:0] x [STEPS+1];
  logic signed [CORDIC_BITS-1:0] y [STEPS+1];
  angle_t                        z [STEPS+1];
  logic [STEPS:0]                zero;
  logic signed [CORDIC_BITS-1:0] x_in;
  logic signed [CORDIC_BITS-1:0] y_in;

  always_comb begin
    x_in = CORDIC_BITS'(re) <<< SHIFT;
    y_in = CORDIC_BITS'(im) <<< SHIFT;
  end

  always_ff @(posedge clk) begin
    zero[0] <= (re == '0) && (im == '0);
    // turn left half plane by a half turn
    if (x_in[CORDIC_BITS-1]) begin
      x[0] <= -x_in;
      y[0] <= -y_in;
      z[0] <= HALF_TURN;
    end else begin
      x[0] <= x_in;
      y[0] <= y_in;
      z[0] <= '0;
    end
    for (int i = 0; i < STEPS; i++) begin
      zero[i+1] <= zero[i];
      if (!y[i][CORDIC_BITS-1]) begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ANGLE_TAB[i];
      end else begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ANGLE_TAB[i];
      end
    end
  end

  assign phase = zero[STEPS] ? '0 : z[STEPS];

endmodule

FILE: rtl/sce_front.sv
module sce_front #(
  parameter int STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  sce_pkg::item_t item,
  output logic           out_valid,
  output sce_pkg::word_t out_word
);
  import sce_pkg::*;

  localparam int SQ_BITS = 2 * SAMPLE_BITS;

  item_t              in_reg;
  logic               in_valid;
  logic [SQ_BITS-1:0] sq_lr, sq_li, sq_rr, sq_ri;
  logic [SQ_BITS:0]   mag_l, mag_r;
  word_t              pipe [STEPS+1];
  logic [STEPS:0]     vld;
  angle_t             phase_l, phase_r;

  sce_cordic #(.STEPS(STEPS)) u_cordic_left (
    .clk  (clk),
    .re   (in_reg.left_re),
    .im   (in_reg.left_im),
    .phase(phase_l)
  );

  sce_cordic #(.STEPS(STEPS)) u_cordic_right (
    .clk  (clk),
    .re   (in_reg.right_re),
    .im   (in_reg.right_im),
    .phase(phase_r)
  );

  assign mag_l = {1'b0, sq_lr} + {1'b0, sq_li};
  assign mag_r = {1'b0, sq_rr} + {1'b0, sq_ri};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      vld      <= '0;
    end else begin
      in_valid <= take;
      vld      <= {vld[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    in_reg <= item;
    sq_lr  <= SQ_BITS'(in_reg.left_re * in_reg.left_re);
    sq_li  <= SQ_BITS'(in_reg.left_im * in_reg.left_im);
    sq_rr  <= SQ_BITS'(in_reg.right_re * in_reg.right_re);
    sq_ri  <= SQ_BITS'(in_reg.right_im * in_reg.right_im);
    pipe[0].item        <= in_reg;
    pipe[0].pick_right  <= 1'b0;
    pipe[0].phase_left  <= '0;
    pipe[0].phase_right <= '0;
    pipe[1].item        <= pipe[0].item;
    // left wins a tie
    pipe[1].pick_right  <= mag_l > mag_r;
    pipe[1].phase_left  <= pipe[0].phase_left;
    pipe[1].phase_right <= pipe[0].phase_right;
    for (int k = 1; k < STEPS; k++) begin
      pipe[k+1] <= pipe[k];
    end
  end

  always_comb begin
    out_valid            = vld[STEPS];
    out_word             = pipe[STEPS];
    out_word.phase_left  = phase_l;
    out_word.phase_right = phase_r;
  end

endmodule

FILE: rtl/sce_queue.sv
module sce_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sce_pkg::word_t         wdata,
  input  logic                   pop,
  output logic                   nonempty,
  output sce_pkg::word_t         rdata,
  output sce_pkg::queue_status_t status
);
  import sce_pkg::*;

  word_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_pop;

  assign nonempty           = count != '0;
  assign do_pop             = pop && nonempty;
  assign rdata              = mem[rd_ptr];
  assign status.full        = count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
  assign status.almost_full = count >= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !status.full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_PTR_BITS+1)'(push && !status.full)
                     - (QUEUE_PTR_BITS+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !status.full) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: rtl/sce_back.sv
module sce_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sce_pkg::word_t   in_word,
  input  sce_pkg::gain_t   gain_left,
  input  sce_pkg::gain_t   gain_center,
  input  sce_pkg::gain_t   gain_right,
  output logic             done,
  output sce_pkg::result_t result
);
  import sce_pkg::*;

  localparam int PAY_STAGES = 9;
  localparam int CEN_BITS   = SAMPLE_BITS + 1;
  localparam int SIDE_BITS  = SAMPLE_BITS + 2;
  localparam int CP_BITS    = SAMPLE_BITS + WEIGHT_BITS + 1;
  localparam int PB         = SIDE_BITS + GAIN_BITS;
  localparam int SUM_BITS   = PB + 1;
  localparam logic signed [SUM_BITS-1:0] HI    = SUM_BITS'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [SUM_BITS-1:0] LO    = ~HI;
  localparam logic signed [SUM_BITS-1:0] ROUND = SUM_BITS'(8192);
  localparam logic signed [CP_BITS-1:0]  C_RND = CP_BITS'(32768);

  typedef struct packed {
    item_t   item;
    sample_t cen_re;
    sample_t cen_im;
  } back_pay_t;

  back_pay_t              pay [1:PAY_STAGES];
  logic [PAY_STAGES+1:1]  vld;
  angle_t                 d, d_fold;
  logic [ANGLE_BITS:0]    u_wide;
  weight_t                u1, u2, u2_u, u3, a2, a4, a8, a16, a8_d, w;
  weight_t                a;
  logic signed [CP_BITS-1:0]   cp_re, cp_im;
  logic signed [CEN_BITS-1:0]  c_re, c_im;
  logic signed [SIDE_BITS-1:0] s_lr, s_li, s_rr, s_ri;
  logic signed [PB-1:0]        p_lr, p_li, p_rr, p_ri, p_cr, p_ci;
  logic                        last10;

  function automatic sample_t sat(input logic signed [PB-1:0] ps,
                                  input logic signed [PB-1:0] pc);
    logic signed [SUM_BITS-1:0] v;
    v = (SUM_BITS'(ps) + SUM_BITS'(pc) + ROUND) >>> 14;
    if (v > HI) begin
      v = HI;
    end else if (v < LO) begin
      v = LO;
    end
    return sample_t'(v[SAMPLE_BITS-1:0]);
  endfunction

  // fold the phase distance to at most a half turn
  always_comb begin
    d      = in_word.phase_left - in_word.phase_right;
    d_fold = (d > HALF_TURN) ? -d : d;
    u_wide = ((ANGLE_BITS+1)'(d_fold) + (ANGLE_BITS+1)'(16384)) >> 15;
    a      = WEIGHT_ONE - u3;
    cp_re  = CP_BITS'(pay[8].cen_re) * CP_BITS'($signed({1'b0, w})) + C_RND;
    cp_im  = CP_BITS'(pay[8].cen_im) * CP_BITS'($signed({1'b0, w})) + C_RND;
    s_lr   = SIDE_BITS'(pay[9].item.left_re) - SIDE_BITS'(c_re);
    s_li   = SIDE_BITS'(pay[9].item.left_im) - SIDE_BITS'(c_im);
    s_rr   = SIDE_BITS'(pay[9].item.right_re) - SIDE_BITS'(c_re);
    s_ri   = SIDE_BITS'(pay[9].item.right_im) - SIDE_BITS'(c_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[PAY_STAGES:1], in_valid};
      done <= vld[PAY_STAGES+1];
    end
  end

  always_ff @(posedge clk) begin
    pay[1].item   <= in_word.item;
    pay[1].cen_re <= in_word.pick_right ? in_word.item.right_re : in_word.item.left_re;
    pay[1].cen_im <= in_word.pick_right ? in_word.item.right_im : in_word.item.left_im;
    for (int k = 1; k < PAY_STAGES; k++) begin
      pay[k+1] <= pay[k];
    end
    u1   <= WEIGHT_BITS'(u_wide);
    u2   <= mul16(u1, u1);
    u2_u <= u1;
    u3   <= mul16(u2, u2_u);
    a2   <= mul16(a, a);
    a4   <= mul16(a2, a2);
    a8   <= mul16(a4, a4);
    a16  <= mul16(a8, a8);
    a8_d <= a8;
    w    <= mul16(a16, a8_d);
    c_re <= cp_re[16 +: CEN_BITS];
    c_im <= cp_im[16 +: CEN_BITS];
    p_lr <= PB'(s_lr) * PB'(gain_left);
    p_li <= PB'(s_li) * PB'(gain_left);
    p_rr <= PB'(s_rr) * PB'(gain_right);
    p_ri <= PB'(s_ri) * PB'(gain_right);
    p_cr <= PB'(c_re) * PB'(gain_center);
    p_ci <= PB'(c_im) * PB'(gain_center);
    last10 <= pay[9].item.last_bin;
    result.out_left_re  <= sat(p_lr, p_cr);
    result.out_left_im  <= sat(p_li, p_ci);
    result.out_right_re <= sat(p_rr, p_cr);
    result.out_right_im <= sat(p_ri, p_ci);
    result.frame_end    <= last10;
  end

endmodule

FILE: rtl/stereo_center_bin_extractor.sv
// A taken start passes the phase front, queue and mixing back, then strobes on done.
// Throughput: one bin per cycle unless busy; phase pipelines and weight chain fully staged.
// busy only rises if the queue between phase front and mixing back is almost full.
// Results cannot be held off; done marks a single cycle.
// Reset (rst, synchronous): pipelines and queue empty, all three gains back to 1.0.
module stereo_center_bin_extractor #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  sce_pkg::item_t                item,
  output logic                          done,
  output sce_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sce_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sce_pkg::DATA_BITS-1:0] pwdata,
  output logic [sce_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import sce_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ANGLE_STEPS_MAX) ? ANGLE_STEPS_MAX : CORDIC_STEPS;

  gain_t         gain_left, gain_center, gain_right;
  reg_index_t    reg_index;
  logic          front_valid, q_nonempty;
  word_t         front_word, q_word;
  queue_status_t q_status;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[ADDR_BITS-1:2]);
  assign busy      = q_status.almost_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_left   <= GAIN_UNITY;
      gain_center <= GAIN_UNITY;
      gain_right  <= GAIN_UNITY;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_GAIN_LEFT:   gain_left   <= gain_t'(pwdata[GAIN_BITS-1:0]);
        REG_GAIN_CENTER: gain_center <= gain_t'(pwdata[GAIN_BITS-1:0]);
        REG_GAIN_RIGHT:  gain_right  <= gain_t'(pwdata[GAIN_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_GAIN_LEFT:   prdata = DATA_BITS'(gain_left);
      REG_GAIN_CENTER: prdata = DATA_BITS'(gain_center);
      REG_GAIN_RIGHT:  prdata = DATA_BITS'(gain_right);
      default:         prdata = '0;
    endcase
  end

  sce_front #(.STEPS(STEPS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (start && !busy),
    .item     (item),
    .out_valid(front_valid),
    .out_word (front_word)
  );

  sce_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_valid),
    .wdata   (front_word),
    .pop     (q_nonempty),
    .nonempty(q_nonempty),
    .rdata   (q_word),
    .status  (q_status)
  );

  sce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_nonempty),
    .in_word    (q_word),
    .gain_left  (gain_left),
    .gain_center(gain_center),
    .gain_right (gain_right),
    .done       (done),
    .result     (result)
  );

endmodule
